// File: design/icaf_pkg.sv
// ----------------------------------------------------------------------------
// icaf_pkg
// widths and constants shared by the attitude filter, its channels and checker
// ----------------------------------------------------------------------------
package icaf_pkg;

    localparam int SampleW    = 16;
    localparam int AngleW     = 32;
    localparam int AccAngW    = 16;
    localparam int AbsW       = 10;
    localparam int SqW        = 19;
    localparam int NumW       = 31;
    localparam int QuoW       = 13;
    localparam int MulW       = 24;

    localparam int GyroScale  = 25;
    localparam int GyroShift  = 13;
    localparam int AccShift   = 6;
    localparam int AtanGain   = 5729;
    localparam int SmallGain  = 28;
    localparam int Recip100   = 10737419;
    localparam int RecipShift = 30;
    localparam int Deg90      = 9000;
    localparam int Deg180     = 18000;
    localparam int BlendShift = 8;

endpackage

// File: design/icaf_sample_if.sv
// ----------------------------------------------------------------------------
// icaf_sample_if
// valid/ready channel carrying one raw imu sample
// ----------------------------------------------------------------------------
interface icaf_sample_if;

    logic                                valid;
    logic                                ready;
    logic signed [icaf_pkg::SampleW-1:0] accel_x;
    logic signed [icaf_pkg::SampleW-1:0] accel_y;
    logic signed [icaf_pkg::SampleW-1:0] accel_z;
    logic signed [icaf_pkg::SampleW-1:0] gyro_x;
    logic signed [icaf_pkg::SampleW-1:0] gyro_y;
    logic signed [icaf_pkg::SampleW-1:0] gyro_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        input  ready
    );

    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        output ready
    );

endinterface

// File: design/icaf_att_if.sv
// ----------------------------------------------------------------------------
// icaf_att_if
// valid/ready channel carrying one fused attitude result
// ----------------------------------------------------------------------------
interface icaf_att_if;

    logic                               valid;
    logic                               ready;
    logic signed [icaf_pkg::AngleW-1:0] pitch_angle;
    logic signed [icaf_pkg::AngleW-1:0] roll_angle;
    logic signed [icaf_pkg::AngleW-1:0] yaw_angle;

    modport source (
        output valid, pitch_angle, roll_angle, yaw_angle,
        input  ready
    );

    modport sink (
        input  valid, pitch_angle, roll_angle, yaw_angle,
        output ready
    );

endinterface

// File: design/imu_complementary_attitude_filter_core.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_core
// gyro integration of pitch, roll and yaw, with pitch and roll pulled toward
// an atan2 estimate from the accelerometer through a shared multiplier and a
// restoring divider
//
//   channel     dir  handshake       payload
//   i_sample    in   valid / ready   accel_x/y/z, gyro_x/y/z
//   o_attitude  out  valid / ready   pitch_angle, roll_angle, yaw_angle
//
// a sample runs from accept to the next accept as follows: each of the two
// tilt axes takes six passes through the shared multiplier, 13 divider steps
// and four further steps (prep, denominator, quadrant fix, blend), then the
// block loads the output register and returns to idle to take the next
// transaction; a result left waiting holds the block in its last state until
// the output register frees, and the next sample is taken meanwhile once the
// result is registered; reset is synchronous and zeroes the angles
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    icaf_sample_if.sink   i_sample,
    icaf_att_if.source    o_attitude
);

    localparam int SW = icaf_pkg::SampleW;
    localparam int AW = icaf_pkg::AngleW;
    localparam int GW = SW + 5;
    localparam int YW = SW + 1;
    localparam int DW = icaf_pkg::SqW;
    localparam int RW = icaf_pkg::NumW;
    localparam int VW = AW + icaf_pkg::BlendShift + 1;
    localparam int CW = $clog2(icaf_pkg::QuoW);

    localparam logic [2:0] MS_BIG2   = 3'd0;
    localparam logic [2:0] MS_SMALL2 = 3'd1;
    localparam logic [2:0] MS_SCALE  = 3'd2;
    localparam logic [2:0] MS_RECIP  = 3'd3;
    localparam logic [2:0] MS_CROSS  = 3'd4;
    localparam logic [2:0] MS_GAIN   = 3'd5;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_DEN   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_FIX   = 8'b0010_0000,
        S_BLEND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    function automatic logic signed [AW-1:0] gyro_step(input logic signed [SW-1:0] g);
        logic signed [GW-1:0] p;
        p = GW'(g) * GW'(icaf_pkg::GyroScale);
        return AW'(p >>> icaf_pkg::GyroShift);
    endfunction

    t_state                         r_state;
    logic                           r_axis;
    logic [2:0]                     r_mstep;
    logic [CW-1:0]                  r_cnt;
    logic signed [SW-1:0]           r_acc_x;
    logic signed [SW-1:0]           r_acc_y;
    logic signed [SW-1:0]           r_acc_z;
    logic signed [AW-1:0]           r_pitch;
    logic signed [AW-1:0]           r_roll;
    logic signed [AW-1:0]           r_yaw;
    logic                           r_sx_neg;
    logic                           r_sy_neg;
    logic                           r_zero_vec;
    logic                           r_le;
    logic                           r_den_zero;
    logic [icaf_pkg::AbsW-1:0]      r_big;
    logic [icaf_pkg::AbsW-1:0]      r_small;
    logic [DW-1:0]                  r_big2;
    logic [icaf_pkg::MulW-1:0]      r_tmp;
    logic [RW-1:0]                  r_num;
    logic [RW-1:0]                  r_rem;
    logic [RW-1:0]                  r_dsh;
    logic [icaf_pkg::QuoW-1:0]      r_quo;
    logic signed [icaf_pkg::AccAngW-1:0] r_acc_ang;
    logic                           r_out_valid;
    logic signed [AW-1:0]           r_out_pitch;
    logic signed [AW-1:0]           r_out_roll;
    logic signed [AW-1:0]           r_out_yaw;

    logic                           w_in_fire;
    logic                           w_out_fire;
    logic                           w_load;
    logic signed [YW-1:0]           w_y;
    logic signed [YW-1:0]           w_x;
    logic signed [YW-1:0]           w_sy;
    logic signed [YW-1:0]           w_sx;
    logic [icaf_pkg::AbsW-1:0]      w_ay;
    logic [icaf_pkg::AbsW-1:0]      w_ax;
    logic [icaf_pkg::MulW-1:0]      w_mul_a;
    logic [icaf_pkg::MulW-1:0]      w_mul_b;
    logic [2*icaf_pkg::MulW-1:0]    w_mul_p;
    logic [DW-1:0]                  w_den;
    logic                           n_ge;
    logic signed [icaf_pkg::AccAngW-1:0] n_ang;
    logic signed [icaf_pkg::AccAngW-1:0] w_q;
    logic signed [icaf_pkg::AccAngW-1:0] w_a0;
    logic signed [icaf_pkg::AccAngW-1:0] w_a1;
    logic signed [AW-1:0]           w_cur;
    logic signed [VW-1:0]           w_blend_v;
    logic signed [AW-1:0]           n_blend;

    assign w_in_fire  = i_sample.valid && i_sample.ready;
    assign w_out_fire = r_out_valid && o_attitude.ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_attitude.ready);

    assign i_sample.ready         = (r_state == S_IDLE);
    assign o_attitude.valid       = r_out_valid;
    assign o_attitude.pitch_angle = r_out_pitch;
    assign o_attitude.roll_angle  = r_out_roll;
    assign o_attitude.yaw_angle   = r_out_yaw;

    // atan2 operands for the axis in work
    always_comb begin
        w_y  = r_axis ? YW'(r_acc_y) : -YW'(r_acc_x);
        w_x  = YW'(r_acc_z);
        w_sy = w_y >>> icaf_pkg::AccShift;
        w_sx = w_x >>> icaf_pkg::AccShift;
        w_ay = w_sy[YW-1] ? icaf_pkg::AbsW'(-w_sy) : icaf_pkg::AbsW'(w_sy);
        w_ax = w_sx[YW-1] ? icaf_pkg::AbsW'(-w_sx) : icaf_pkg::AbsW'(w_sx);
    end

    // shared multiplier
    always_comb begin
        unique case (r_mstep)
            MS_BIG2: begin
                w_mul_a = icaf_pkg::MulW'(r_big);
                w_mul_b = icaf_pkg::MulW'(r_big);
            end
            MS_SMALL2: begin
                w_mul_a = icaf_pkg::MulW'(r_small);
                w_mul_b = icaf_pkg::MulW'(r_small);
            end
            MS_SCALE: begin
                w_mul_a = r_tmp;
                w_mul_b = icaf_pkg::MulW'(icaf_pkg::SmallGain);
            end
            MS_RECIP: begin
                w_mul_a = r_tmp;
                w_mul_b = icaf_pkg::MulW'(icaf_pkg::Recip100);
            end
            MS_CROSS: begin
                w_mul_a = icaf_pkg::MulW'(r_big);
                w_mul_b = icaf_pkg::MulW'(r_small);
            end
            MS_GAIN: begin
                w_mul_a = icaf_pkg::MulW'(r_num);
                w_mul_b = icaf_pkg::MulW'(icaf_pkg::AtanGain);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    assign w_den = r_big2 + DW'(r_tmp);
    assign n_ge  = (r_rem >= r_dsh);

    // quadrant fixes
    always_comb begin
        w_q  = r_den_zero ? '0 : icaf_pkg::AccAngW'(r_quo);
        w_a0 = r_le ? w_q : icaf_pkg::AccAngW'(icaf_pkg::Deg90) - w_q;
        w_a1 = r_sx_neg ? icaf_pkg::AccAngW'(icaf_pkg::Deg180) - w_a0 : w_a0;
        if (r_zero_vec) begin
            n_ang = '0;
        end else begin
            n_ang = r_sy_neg ? -w_a1 : w_a1;
        end
    end

    // (angle*255 + acc) >> 8, floor
    always_comb begin
        w_cur     = r_axis ? r_roll : r_pitch;
        w_blend_v = (VW'(w_cur) <<< icaf_pkg::BlendShift) - VW'(w_cur) + VW'(r_acc_ang);
        n_blend   = w_blend_v[AW+icaf_pkg::BlendShift-1:icaf_pkg::BlendShift];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_mstep     <= MS_BIG2;
            r_cnt       <= '0;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_yaw       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_acc_x <= i_sample.accel_x;
                        r_acc_y <= i_sample.accel_y;
                        r_acc_z <= i_sample.accel_z;
                        r_pitch <= r_pitch + gyro_step(i_sample.gyro_x);
                        r_roll  <= r_roll + gyro_step(i_sample.gyro_y);
                        r_yaw   <= r_yaw + gyro_step(i_sample.gyro_z);
                        r_axis  <= 1'b0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_sx_neg   <= w_sx[YW-1];
                    r_sy_neg   <= w_sy[YW-1];
                    r_zero_vec <= (w_y == '0) && (w_x == '0);
                    r_le       <= (w_ay <= w_ax);
                    r_big      <= (w_ay <= w_ax) ? w_ax : w_ay;
                    r_small    <= (w_ay <= w_ax) ? w_ay : w_ax;
                    r_mstep    <= MS_BIG2;
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    unique case (r_mstep)
                        MS_BIG2:   r_big2 <= w_mul_p[DW-1:0];
                        MS_SMALL2: r_tmp  <= w_mul_p[icaf_pkg::MulW-1:0];
                        MS_SCALE:  r_tmp  <= w_mul_p[icaf_pkg::MulW-1:0];
                        MS_RECIP:  r_tmp  <= icaf_pkg::MulW'(w_mul_p >> icaf_pkg::RecipShift);
                        MS_CROSS:  r_num  <= w_mul_p[RW-1:0];
                        MS_GAIN:   r_num  <= w_mul_p[RW-1:0];
                        default:   r_num  <= r_num;
                    endcase
                    if (r_mstep == MS_GAIN) begin
                        r_state <= S_DEN;
                    end
                    r_mstep <= r_mstep + 3'd1;
                end
                S_DEN: begin
                    r_rem      <= r_num;
                    r_dsh      <= RW'(w_den) << (icaf_pkg::QuoW - 1);
                    r_den_zero <= (w_den == '0);
                    r_quo      <= '0;
                    r_cnt      <= CW'(icaf_pkg::QuoW - 1);
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    if (n_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_quo <= {r_quo[icaf_pkg::QuoW-2:0], n_ge};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_acc_ang <= n_ang;
                    r_state   <= S_BLEND;
                end
                S_BLEND: begin
                    if (r_axis) begin
                        r_roll  <= n_blend;
                        r_state <= S_DONE;
                    end else begin
                        r_pitch <= n_blend;
                        r_axis  <= 1'b1;
                        r_state <= S_PREP;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_pitch <= r_pitch;
                        r_out_roll  <= r_roll;
                        r_out_yaw   <= r_yaw;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/icaf_checker.sv
// ----------------------------------------------------------------------------
// icaf_checker
// port-level checks on the attitude filter, bound to the top level
// ----------------------------------------------------------------------------
module icaf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [icaf_pkg::AngleW-1:0] i_pitch,
    input logic signed [icaf_pkg::AngleW-1:0] i_roll,
    input logic signed [icaf_pkg::AngleW-1:0] i_yaw
);

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pitch) && $stable(i_roll) && $stable(i_yaw))
    else $error("stalled result changed");

    // reset leaves the block ready and empty
    assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
    else $error("block not idle after reset");

    // a transaction keeps the input side closed right after it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
    else $error("ready right after a transaction");

    // both axes still in work well after the transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##40 !i_in_ready)
    else $error("sample finished too early");

endmodule

bind imu_complementary_attitude_filter_core icaf_checker u_icaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_attitude.valid),
    .i_out_ready (o_attitude.ready),
    .i_pitch     (o_attitude.pitch_angle),
    .i_roll      (o_attitude.roll_angle),
    .i_yaw       (o_attitude.yaw_angle)
);
